>>> design/tksi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the top-k sorted insertion table.
package tksi_pkg;

    localparam int ScoreW = 32;
    localparam int StampW = 32;
    localparam int TagW   = 16;
    localparam int IndexW = 4;
    localparam int RankW  = 4;

    localparam int SDataW = 88;
    localparam int MDataW = 88;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed {
        logic load;
        logic exec;
    } tksi_cmd_t;

endpackage

>>> design/tksi_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences capture, execution and delivery of one word.
module tksi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tksi_pkg::tksi_cmd_t cmd
);
    import tksi_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);
    assign cmd.load = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec = (state_reg == ST_EXEC);

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("accepted word not executed in the following cycle");
    a_exec_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid && !s_tready)
        else $error("result not presented after execution");
`endif

endmodule

>>> design/tksi_datapath.sv
`timescale 1ns / 1ps
// Datapath: row of ranked cells with parallel compare, shift insertion and indexed read.
module tksi_datapath #(
    parameter int DEPTH = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tksi_pkg::tksi_cmd_t              cmd,
    input  tksi_pkg::op_t                    opcode,
    input  logic [tksi_pkg::ScoreW-1:0]      score_in,
    input  logic [tksi_pkg::StampW-1:0]      stamp_in,
    input  logic [tksi_pkg::TagW-1:0]        tag_in,
    input  logic [tksi_pkg::IndexW-1:0]      read_index,
    output logic [tksi_pkg::RankW-1:0]       rank,
    output logic                             entry_valid,
    output logic [tksi_pkg::ScoreW-1:0]      score_out,
    output logic [tksi_pkg::StampW-1:0]      stamp_out,
    output logic [tksi_pkg::TagW-1:0]        tag_out
);
    import tksi_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ScoreW-1:0] cell_score_reg [DEPTH];
    logic [StampW-1:0] cell_stamp_reg [DEPTH];
    logic [TagW-1:0]   cell_tag_reg   [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    op_t               op_reg;
    logic [ScoreW-1:0] score_reg;
    logic [StampW-1:0] stamp_reg;
    logic [TagW-1:0]   tag_reg;
    logic [IndexW-1:0] index_reg;
    logic [DEPTH-1:0]  lower_reg;
    logic [DEPTH-1:0]  lower_next;

    logic [DEPTH-1:0]  place;
    logic [CW-1:0]     pos;
    logic              insert_ok;
    logic              rd_hit;
    logic [IW-1:0]     rd_sel;

    logic [RankW-1:0]  rank_reg;
    logic              valid_reg;
    logic [ScoreW-1:0] score_out_reg;
    logic [StampW-1:0] stamp_out_reg;
    logic [TagW-1:0]   tag_out_reg;

    // A cell is lower when it is empty or holds a strictly smaller score.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lower_next[i] = (count_reg <= CW'(i)) || (cell_score_reg[i] < score_in);
        end
    end

    // The table is sorted, so the lower flags are monotonic and one edge marks the slot.
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                place[i] = lower_reg[i];
            end else begin
                place[i] = lower_reg[i] && !lower_reg[i-1];
            end
            if (place[i]) begin
                pos = pos | CW'(i);
            end
        end
    end

    assign insert_ok = lower_reg[DEPTH-1];
    assign rd_hit    = (32'(index_reg) < DEPTH) && (32'(index_reg) < 32'(count_reg));
    assign rd_sel    = IW'(index_reg);

    always_comb begin
        count_next = count_reg;
        if (cmd.exec && (op_reg == OP_INSERT) && insert_ok && (32'(count_reg) < DEPTH)) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= opcode;
            score_reg <= score_in;
            stamp_reg <= stamp_in;
            tag_reg   <= tag_in;
            index_reg <= read_index;
            lower_reg <= lower_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && (op_reg == OP_INSERT)) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (place[i]) begin
                    cell_score_reg[i] <= score_reg;
                    cell_stamp_reg[i] <= stamp_reg;
                    cell_tag_reg[i]   <= tag_reg;
                end else if ((i > 0) && lower_reg[(i > 0) ? i - 1 : 0]) begin
                    cell_score_reg[i] <= cell_score_reg[(i > 0) ? i - 1 : 0];
                    cell_stamp_reg[i] <= cell_stamp_reg[(i > 0) ? i - 1 : 0];
                    cell_tag_reg[i]   <= cell_tag_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (op_reg == OP_READ) begin
                rank_reg  <= index_reg;
                valid_reg <= rd_hit;
                if (rd_hit) begin
                    score_out_reg <= cell_score_reg[rd_sel];
                    stamp_out_reg <= cell_stamp_reg[rd_sel];
                    tag_out_reg   <= cell_tag_reg[rd_sel];
                end else begin
                    score_out_reg <= '0;
                    stamp_out_reg <= '0;
                    tag_out_reg   <= '0;
                end
            end else begin
                rank_reg      <= insert_ok ? RankW'(pos) : RankW'(DEPTH);
                valid_reg     <= insert_ok;
                score_out_reg <= '0;
                stamp_out_reg <= '0;
                tag_out_reg   <= '0;
            end
        end
    end

    assign rank        = rank_reg;
    assign entry_valid = valid_reg;
    assign score_out   = score_out_reg;
    assign stamp_out   = stamp_out_reg;
    assign tag_out     = tag_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= DEPTH)
        else $error("entry count exceeds table depth");
    a_read_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (op_reg == OP_READ) |=> $stable(count_reg))
        else $error("read changed the entry count");
`endif

endmodule

>>> design/top_k_sorted_insert_top.sv
`timescale 1ns / 1ps
// Top level of the top-k sorted insertion table with stream ports.
//
//  Channel | Dir | tdata (low bit up)                               | tuser
//  s_      | in  | score_in 32, stamp_in 32, tag_in 16, read_index 4 | opcode
//  m_      | out | rank 4, score_out 32, stamp_out 32, tag_out 16    | entry_valid
//
// A word is captured, and every cell compared with it, at the accepting edge; in ST_EXEC the
// cells are shifted or read and the result is registered, and m_tvalid is high in ST_DONE.
// s_tready returns in the cycle after the result is taken, as the controller re-enters ST_IDLE.
// The controller handles one word at a time; a stalled result holds s_tready low.
// Synchronous active-low reset empties the table; the cell contents are not cleared.
module top_k_sorted_insert_top #(
    parameter int DEPTH = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tksi_pkg::SDataW-1:0]  s_tdata,  // score_in, stamp_in, tag_in, read_index
    input  logic                         s_tuser,  // opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tksi_pkg::MDataW-1:0]  m_tdata,  // rank, score_out, stamp_out, tag_out
    output logic                         m_tuser   // entry_valid
);
    import tksi_pkg::*;

    tksi_cmd_t         cmd;
    logic [RankW-1:0]  rank;
    logic              entry_valid;
    logic [ScoreW-1:0] score_out;
    logic [StampW-1:0] stamp_out;
    logic [TagW-1:0]   tag_out;

    tksi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tksi_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .opcode      (op_t'(s_tuser)),
        .score_in    (s_tdata[31:0]),
        .stamp_in    (s_tdata[63:32]),
        .tag_in      (s_tdata[79:64]),
        .read_index  (s_tdata[83:80]),
        .rank        (rank),
        .entry_valid (entry_valid),
        .score_out   (score_out),
        .stamp_out   (stamp_out),
        .tag_out     (tag_out)
    );

    assign m_tdata = {4'b0, tag_out, stamp_out, score_out, rank};
    assign m_tuser = entry_valid;

endmodule
